/* sv/rcps_pkg.sv */
// rcps_pkg: shared types, register indexes and widths for the rc pulse switch
// depends on: nothing; imported by every module of the block
package rcps_pkg;

    // pulse width counter width and its saturation value
    localparam int unsigned COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // field widths of the configuration registers
    localparam int unsigned THR_BITS      = 16;
    localparam int unsigned TIMEOUT_BITS  = 10;
    localparam int unsigned MODE_BITS     = 2;
    localparam int unsigned PRESCALE_BITS = 8;
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned CFG_DATA_BITS = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_ON_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_OFF_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FS_TIMEOUT    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FS_MODE       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TICK_PERIOD   = 3'd4;

    // failsafe output modes
    localparam logic [MODE_BITS-1:0] FS_FORCE_OFF = 2'd0;
    localparam logic [MODE_BITS-1:0] FS_FORCE_ON  = 2'd1;
    localparam logic [MODE_BITS-1:0] FS_HOLD      = 2'd2;

    // register reset values
    localparam logic [THR_BITS-1:0]      ON_THRESHOLD_RST  = 16'd400;
    localparam logic [THR_BITS-1:0]      OFF_THRESHOLD_RST = 16'd350;
    localparam logic [TIMEOUT_BITS-1:0]  FS_TIMEOUT_RST    = 10'd250;
    localparam logic [PRESCALE_BITS-1:0] TICK_PERIOD_RST   = 8'd250;

    // configuration register bank
    typedef struct packed {
        logic [THR_BITS-1:0]      on_threshold;
        logic [THR_BITS-1:0]      off_threshold;
        logic [TIMEOUT_BITS-1:0]  fs_timeout;
        logic [MODE_BITS-1:0]     failsafe_mode;
        logic [PRESCALE_BITS-1:0] tick_period;
    } rcps_cfg_t;

    // one result transfer
    typedef struct packed {
        logic switch_out;
        logic failsafe_active;
        logic pulse_done;
    } rcps_result_t;

endpackage

/* sv/rc_pulse_switch_failsafe.sv */
// rc_pulse_switch_failsafe: top level with input register, core and result register
// depends on: rcps_pkg, rcps_cfg, rcps_core
//
//  channel   signals                                   width  direction
//  in        in_valid, in_stall, rx_level              1      sample in
//  out       out_valid, out_stall, switch_out,
//            failsafe_active, pulse_done               1 each result out
//  cfg       cfg_we, cfg_index, cfg_data               3/16   register write
//
// one sample per cycle sustained while out_stall is low; a sample passes through the input
// register and then the result register before its result is offered on the output
// valid flags and core state clear on rst_n low, sample and result data are not reset;
// the register bank returns to defaults; a stalled output holds its result; one more
// sample is taken into the input register while the result waits, after which in_stall rises
module rc_pulse_switch_failsafe (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                rx_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                switch_out,
    output logic                                failsafe_active,
    output logic                                pulse_done,
    input  logic                                cfg_we,
    input  logic [rcps_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rcps_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rcps_pkg::*;

    rcps_cfg_t    cfg;
    rcps_result_t core_result;
    rcps_result_t result_reg;

    logic in_valid_reg;
    logic level_reg;
    logic out_valid_reg;
    logic advance;
    logic in_xfer;

    rcps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pipeline control: the input register moves when the result slot frees
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    rcps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (in_valid_reg && advance),
        .level  (level_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (advance || !in_valid_reg)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            level_reg <= rx_level;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            result_reg <= core_result;
    end

    assign out_valid       = out_valid_reg;
    assign switch_out      = result_reg.switch_out;
    assign failsafe_active = result_reg.failsafe_active;
    assign pulse_done      = result_reg.pulse_done;

    // a pulse end always clears failsafe in the same result
    a_done_clears_fs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.pulse_done |-> !result_reg.failsafe_active)
        else $error("pulse end with failsafe still set");

    // forced-off failsafe never drives the switch on
    a_fs_forced_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.failsafe_active && cfg.failsafe_mode == FS_FORCE_OFF
        |-> !result_reg.switch_out)
        else $error("switch on during forced-off failsafe");

    // a new result only appears after the input register held a sample
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a registered sample");

    // the input register stays loaded while the result side is blocked
    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && out_stall |=> in_valid_reg)
        else $error("registered sample lost under stall");

endmodule

/* sv/rcps_cfg.sv */
// rcps_cfg: configuration register bank written through a plain write port
// depends on: rcps_pkg
module rcps_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rcps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [rcps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output rcps_pkg::rcps_cfg_t                  cfg
);
    import rcps_pkg::*;

    rcps_cfg_t cfg_reg;
    rcps_cfg_t cfg_next;

    // register write decode, indexes past the bank are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ON_THRESHOLD:  cfg_next.on_threshold     = cfg_data[THR_BITS-1:0];
                REG_OFF_THRESHOLD: cfg_next.off_threshold    = cfg_data[THR_BITS-1:0];
                REG_FS_TIMEOUT:    cfg_next.fs_timeout       = cfg_data[TIMEOUT_BITS-1:0];
                REG_FS_MODE:       cfg_next.failsafe_mode    = cfg_data[MODE_BITS-1:0];
                REG_TICK_PERIOD:   cfg_next.tick_period      = cfg_data[PRESCALE_BITS-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold     <= ON_THRESHOLD_RST;
            cfg_reg.off_threshold    <= OFF_THRESHOLD_RST;
            cfg_reg.fs_timeout       <= FS_TIMEOUT_RST;
            cfg_reg.failsafe_mode    <= FS_FORCE_OFF;
            cfg_reg.tick_period      <= TICK_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/rcps_core.sv */
// rcps_core: pulse measurement, millisecond prescaler, silence timeout and
// switch decision; state advances on each fire and the result is combinational
// depends on: rcps_pkg
module rcps_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic                   level,
    input  rcps_pkg::rcps_cfg_t    cfg,
    output rcps_pkg::rcps_result_t result
);
    import rcps_pkg::*;

    logic                     prev_level_reg, prev_level_next;
    logic                     measuring_reg, measuring_next;
    logic [COUNT_BITS-1:0]    pulse_count_reg, pulse_count_next;
    logic [PRESCALE_BITS-1:0] prescale_reg, prescale_next;
    logic [TIMEOUT_BITS-1:0]  silence_reg, silence_next;
    logic                     failsafe_reg, failsafe_next;
    logic                     switch_reg, switch_next;
    logic                     primed_reg;

    logic tick;
    logic rise;
    logic hold_high;
    logic fall;
    logic drive;

    // millisecond tick, then edge detection on the pin sample
    always_comb
    begin
        tick      = (prescale_reg >= cfg.tick_period);
        rise      = primed_reg && level && !prev_level_reg;
        hold_high = primed_reg && level && prev_level_reg && measuring_reg;
        fall      = primed_reg && !level && prev_level_reg && measuring_reg;
    end

    // next state; tick is applied before the pulse end
    always_comb
    begin
        prescale_next    = tick ? '0 : prescale_reg + 1'b1;
        silence_next     = silence_reg;
        failsafe_next    = failsafe_reg;
        measuring_next   = measuring_reg;
        pulse_count_next = pulse_count_reg;
        switch_next      = switch_reg;
        prev_level_next  = level;

        if (tick)
        begin
            if (silence_reg < cfg.fs_timeout)
                silence_next = silence_reg + 1'b1;
            else
                failsafe_next = 1'b1;
        end

        if (rise)
        begin
            measuring_next   = 1'b1;
            pulse_count_next = {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
        else if (hold_high)
        begin
            if (pulse_count_reg != COUNT_MAX)
                pulse_count_next = pulse_count_reg + 1'b1;
        end
        else if (fall)
        begin
            // on wins over off when both thresholds match
            if (pulse_count_reg >= cfg.on_threshold)
                switch_next = 1'b1;
            else if (pulse_count_reg <= cfg.off_threshold)
                switch_next = 1'b0;
            measuring_next   = 1'b0;
            pulse_count_next = '0;
            silence_next     = '0;
            failsafe_next    = 1'b0;
        end
    end

    // output drive under failsafe; the unused mode code holds like FS_HOLD
    always_comb
    begin
        if (!failsafe_next)
            drive = switch_next;
        else
        begin
            case (cfg.failsafe_mode)
                FS_FORCE_OFF: drive = 1'b0;
                FS_FORCE_ON:  drive = 1'b1;
                default:      drive = switch_next;
            endcase
        end
        result.switch_out      = drive;
        result.failsafe_active = failsafe_next;
        result.pulse_done      = fall;
    end

    // state registers, advance once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg  <= 1'b0;
            measuring_reg   <= 1'b0;
            pulse_count_reg <= '0;
            prescale_reg    <= '0;
            silence_reg     <= '0;
            failsafe_reg    <= 1'b0;
            switch_reg      <= 1'b0;
            primed_reg      <= 1'b0;
        end
        else if (fire)
        begin
            prev_level_reg  <= prev_level_next;
            measuring_reg   <= measuring_next;
            pulse_count_reg <= pulse_count_next;
            prescale_reg    <= prescale_next;
            silence_reg     <= silence_next;
            failsafe_reg    <= failsafe_next;
            switch_reg      <= switch_next;
            primed_reg      <= 1'b1;
        end
    end

endmodule
